// ===== hw/rtl/rprle_pkg.sv =====
// Shared types and constants for the raster row-pack run-length encoder.
// Used by every module under hw/rtl; depends on nothing.
`default_nettype none

package rprle_pkg;

    localparam int COORD_BITS = 16;
    typedef logic [COORD_BITS-1:0] t_coord;

    localparam logic [7:0] ESC_BYTE = 8'h80;
    localparam logic [7:0] RUN_MAX  = 8'hff;

    // depth mode codes; the fourth code behaves as 24-bit color
    localparam logic [1:0] DEPTH_1BIT  = 2'd0;
    localparam logic [1:0] DEPTH_8BIT  = 2'd1;
    localparam logic [1:0] DEPTH_24BIT = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;
    localparam int CFG_DATA_W = 16;

    // data bytes one pixel can produce before run coding
    localparam int MAX_DATA   = 4;
    localparam int NB_W       = $clog2(MAX_DATA + 1);
    localparam int DATA_IDX_W = $clog2(MAX_DATA);

    localparam int CMD_DEPTH   = 4;
    localparam int CMD_PTR_W   = $clog2(CMD_DEPTH);
    localparam int OBUF_DEPTH  = 4;
    localparam int OBUF_PTR_W  = $clog2(OBUF_DEPTH);

    typedef struct packed {
        logic [7:0] pixel_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_item;
        logic       image_end;
    } t_result;

    typedef struct packed {
        logic [1:0]            depth_mode;
        logic [CFG_DATA_W-1:0] image_width;
        logic [CFG_DATA_W-1:0] image_height;
    } t_cfg;

    // one classified pixel: its data bytes in stream order
    typedef struct packed {
        logic [MAX_DATA-1:0][7:0] bytes;
        logic [NB_W-1:0]          nbytes;
        logic                     done;
    } t_cmd;

    // back end to output buffer
    typedef struct packed {
        logic       wr;
        logic       close;
        logic       image_end;
        logic [7:0] data;
    } t_obuf_wr;

endpackage

`default_nettype wire

// ===== hw/rtl/rprle_front.sv =====
// Front end: accepts pixels, tracks column, row and the bit accumulator,
// and turns each pixel into its list of data bytes. Uses rprle_pkg.
`default_nettype none

module rprle_front import rprle_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_cfg   i_cfg,
    input  wire logic   i_push,
    input  wire t_pixel i_pixel,
    input  wire logic   i_cmd_full,
    output logic        o_accept,
    output logic        o_cmd_push,
    output t_cmd        o_cmd
);

    t_coord     r_column;
    t_coord     r_row;
    logic [7:0] r_acc;
    t_coord     n_column;
    t_coord     n_row;
    logic [7:0] n_acc;

    t_coord     col_next;
    t_coord     row_next;
    logic       row_end;
    logic       img_end;
    logic [7:0] acc_shift;
    logic [2:0] r_low;
    logic [2:0] shamt;
    logic [7:0] flush_bits;
    logic       col_seven;
    logic       have_d;
    logic       pad_bit;
    logic       pad_even;

    assign o_accept   = i_push && !i_cmd_full;
    assign o_cmd_push = o_accept;

    always_comb begin
        acc_shift  = {r_acc[6:0], i_pixel.pixel_index[0]};
        col_next   = r_column + t_coord'(1);
        row_next   = r_row + t_coord'(1);
        row_end    = col_next == t_coord'(i_cfg.image_width);
        img_end    = row_end && (row_next == t_coord'(i_cfg.image_height));
        r_low      = col_next[2:0];
        // partial byte at row end: left-justify the bits of this row
        shamt      = 3'(4'd8 - {1'b0, r_low});
        flush_bits = acc_shift << shamt;
        col_seven  = r_column[2:0] == 3'b111;
        have_d     = col_seven || (row_end && (r_low != 3'd0));
        pad_bit    = row_end && !r_column[3];
        pad_even   = row_end && !r_column[0];
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.done = img_end;
        case (i_cfg.depth_mode)
            DEPTH_1BIT: begin
                o_cmd.bytes[0] = col_seven ? acc_shift : (have_d ? flush_bits : 8'h00);
                o_cmd.nbytes   = NB_W'(have_d) + NB_W'(pad_bit);
            end
            DEPTH_8BIT: begin
                o_cmd.bytes[0] = i_pixel.pixel_index;
                o_cmd.nbytes   = NB_W'(1) + NB_W'(pad_even);
            end
            default: begin
                o_cmd.bytes[0] = i_pixel.blue;
                o_cmd.bytes[1] = i_pixel.green;
                o_cmd.bytes[2] = i_pixel.red;
                o_cmd.nbytes   = NB_W'(3) + NB_W'(pad_even);
            end
        endcase
    end

    always_comb begin
        n_column = r_column;
        n_row    = r_row;
        n_acc    = r_acc;
        if (o_accept) begin
            if (i_cfg.depth_mode == DEPTH_1BIT) begin
                n_acc = acc_shift;
            end
            if (row_end) begin
                n_column = '0;
                n_row    = img_end ? '0 : row_next;
            end else begin
                n_column = col_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column <= '0;
            r_row    <= '0;
            r_acc    <= '0;
        end else begin
            r_column <= n_column;
            r_row    <= n_row;
            r_acc    <= n_acc;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rprle_cmd_fifo.sv =====
// Short queue of classified pixels between the front and back ends.
// Uses rprle_pkg for the entry type and depth.
`default_nettype none

module rprle_cmd_fifo import rprle_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_data,
    output logic      o_full,
    input  wire logic i_pop,
    output t_cmd      o_data,
    output logic      o_empty
);

    t_cmd                 r_mem [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] r_wp;
    logic [CMD_PTR_W-1:0] r_rp;
    logic [CMD_PTR_W:0]   r_count;
    logic [CMD_PTR_W:0]   n_count;

    assign o_full  = r_count == (CMD_PTR_W+1)'(CMD_DEPTH);
    assign o_empty = r_count == '0;
    assign o_data  = r_mem[r_rp];

    always_comb begin
        n_count = r_count + (CMD_PTR_W+1)'(i_push) - (CMD_PTR_W+1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + CMD_PTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + CMD_PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rprle_back.sv =====
// Back end: run-length coder that, while the output buffer has space,
// takes one data byte or writes one coded byte per cycle. Uses rprle_pkg.
`default_nettype none

module rprle_back import rprle_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cmd_valid,
    input  wire t_cmd i_cmd,
    output logic      o_cmd_pop,
    input  wire logic i_obuf_space,
    output t_obuf_wr  o_obuf_wr
);

    logic [NB_W-1:0] r_idx;
    logic [1:0]      r_emit;
    logic            r_run_empty;
    logic [7:0]      r_run_count;
    logic [7:0]      r_run_value;
    logic [NB_W-1:0] n_idx;
    logic [1:0]      n_emit;
    logic            n_run_empty;
    logic [7:0]      n_run_count;
    logic [7:0]      n_run_value;

    logic       have_op;
    logic       last_op;
    logic [7:0] cur_byte;
    logic [1:0] run_len;
    logic       step_last;
    logic       need_flush;
    logic       step_ok;
    logic       complete;
    logic [7:0] emit_byte;

    always_comb begin
        have_op  = r_idx < i_cmd.nbytes;
        last_op  = r_idx == (i_cmd.nbytes - NB_W'(1));
        cur_byte = i_cmd.bytes[r_idx[DATA_IDX_W-1:0]];
        if (r_run_count == 8'h00) begin
            run_len = (r_run_value == ESC_BYTE) ? 2'd2 : 2'd1;
        end else begin
            run_len = 2'd3;
        end
        step_last = r_emit == (run_len - 2'd1);
        if (have_op) begin
            need_flush = !r_run_empty
                && !((cur_byte == r_run_value) && (r_run_count != RUN_MAX));
        end else begin
            // end of image: write out the pending run
            need_flush = i_cmd.done && !r_run_empty;
        end
        step_ok  = !need_flush || (i_obuf_space && step_last);
        complete = i_cmd_valid && step_ok
            && (have_op ? (last_op && !i_cmd.done) : 1'b1);
    end

    always_comb begin
        case (r_emit)
            2'd0:    emit_byte = (r_run_count == 8'h00) ? r_run_value : ESC_BYTE;
            2'd1:    emit_byte = (r_run_count == 8'h00) ? 8'h00 : r_run_count;
            default: emit_byte = r_run_value;
        endcase
    end

    always_comb begin
        n_idx       = r_idx;
        n_emit      = r_emit;
        n_run_empty = r_run_empty;
        n_run_count = r_run_count;
        n_run_value = r_run_value;
        if (i_cmd_valid) begin
            if (need_flush && i_obuf_space && !step_last) begin
                n_emit = r_emit + 2'd1;
            end else if (step_ok) begin
                n_emit = 2'd0;
                if (have_op) begin
                    if (r_run_empty || need_flush) begin
                        n_run_value = cur_byte;
                        n_run_count = 8'h00;
                        n_run_empty = 1'b0;
                    end else begin
                        n_run_count = r_run_count + 8'h01;
                    end
                    n_idx = complete ? '0 : r_idx + NB_W'(1);
                end else begin
                    if (i_cmd.done) begin
                        n_run_empty = 1'b1;
                        n_run_count = 8'h00;
                        n_run_value = 8'h00;
                    end
                    n_idx = '0;
                end
            end
        end
    end

    always_comb begin
        o_cmd_pop           = complete;
        o_obuf_wr.wr        = i_cmd_valid && need_flush && i_obuf_space;
        o_obuf_wr.data      = emit_byte;
        o_obuf_wr.close     = complete;
        o_obuf_wr.image_end = i_cmd.done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_emit      <= 2'd0;
            r_run_empty <= 1'b1;
            r_run_count <= 8'h00;
            r_run_value <= 8'h00;
        end else begin
            r_idx       <= n_idx;
            r_emit      <= n_emit;
            r_run_empty <= n_run_empty;
            r_run_count <= n_run_count;
            r_run_value <= n_run_value;
        end
    end

`ifndef ASSERT_OFF
    a_emit_has_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_emit != 2'd0) |-> !r_run_empty)
        else $error("run write in progress with no pending run");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid |-> (r_idx <= i_cmd.nbytes))
        else $error("byte index past the end of the pixel");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/rprle_out_buf.sv =====
// Output buffer of encoded words; the newest word is held back until its
// pixel is complete so its last-of-pixel flag is known. Uses rprle_pkg.
`default_nettype none

module rprle_out_buf import rprle_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_obuf_wr i_wr,
    output logic          o_space,
    input  wire logic     i_pop,
    output t_result       o_result,
    output logic          o_empty
);

    logic [7:0]            r_data [OBUF_DEPTH];
    logic [OBUF_DEPTH-1:0] r_last;
    logic [OBUF_DEPTH-1:0] r_iend;
    logic [OBUF_PTR_W-1:0] r_wp;
    logic [OBUF_PTR_W-1:0] r_rp;
    logic [OBUF_PTR_W:0]   r_count;
    logic                  r_tail_open;
    logic [OBUF_PTR_W:0]   n_count;
    logic                  n_tail_open;

    logic [OBUF_PTR_W-1:0] tail_ptr;
    logic                  visible;
    logic                  pop;

    always_comb begin
        tail_ptr = r_wp - OBUF_PTR_W'(1);
        // an open tail word is not offered yet
        visible  = (r_count != '0)
            && !((r_count == (OBUF_PTR_W+1)'(1)) && r_tail_open);
        pop      = i_pop && visible;
        n_count  = r_count + (OBUF_PTR_W+1)'(i_wr.wr) - (OBUF_PTR_W+1)'(pop);
        if (i_wr.wr) begin
            n_tail_open = !i_wr.close;
        end else if (i_wr.close) begin
            n_tail_open = 1'b0;
        end else begin
            n_tail_open = r_tail_open;
        end
    end

    assign o_space               = r_count != (OBUF_PTR_W+1)'(OBUF_DEPTH);
    assign o_empty               = !visible;
    assign o_result.out_byte     = r_data[r_rp];
    assign o_result.last_of_item = r_last[r_rp];
    assign o_result.image_end    = r_iend[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_wr.wr) begin
            r_data[r_wp] <= i_wr.data;
            r_last[r_wp] <= i_wr.close;
            r_iend[r_wp] <= i_wr.close && i_wr.image_end;
        end else if (i_wr.close && r_tail_open) begin
            r_last[tail_ptr] <= 1'b1;
            r_iend[tail_ptr] <= i_wr.image_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_rp        <= '0;
            r_count     <= '0;
            r_tail_open <= 1'b0;
        end else begin
            if (i_wr.wr) begin
                r_wp <= r_wp + OBUF_PTR_W'(1);
            end
            if (pop) begin
                r_rp <= r_rp + OBUF_PTR_W'(1);
            end
            r_count     <= n_count;
            r_tail_open <= n_tail_open;
        end
    end

`ifndef ASSERT_OFF
    a_tail_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail_open |-> (r_count != '0))
        else $error("open tail word with an empty buffer");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr.wr |-> (r_count != (OBUF_PTR_W+1)'(OBUF_DEPTH)))
        else $error("word written into a full output buffer");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/raster_row_pack_rle_encoder.sv =====
// Top level of the raster row-pack run-length encoder: configuration
// registers, front end, pixel queue, run coder and output buffer.
// Depends on rprle_pkg and the rprle_* modules.
//
// Pixels enter through a queue-like port (push/full) and encoded words
// leave through another (empty/pop); the two sides stall independently.
// The run coder handles one data byte per cycle unless a run write or a
// full output buffer holds it, and writes at most one encoded word per
// cycle, so throughput is set by the number of data bytes and encoded
// words: a 24-bit pixel has 3 data bytes (4 on a row end that needs a pad
// byte), an 8-bit pixel 1 (2 with a pad), a 1-bit pixel at most 1 (up to
// 2 at row end). A data byte that closes a run waits while the run is
// written: one word for a plain byte, two for an escaped 0x80, three for
// a repeat run; the last pixel of an image also writes the final run. With
// both queues empty a word that closes its pixel is offered once the pixel
// has passed the pixel queue and the output buffer; any other word waits
// until the next word is written, and bytes that only extend a run give no
// word until the run is closed. The last word of a pixel is offered only
// once the pixel is fully coded. Write configuration only while idle.
`default_nettype none

module raster_row_pack_rle_encoder import rprle_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  push,
    output logic                       full,
    input  wire t_pixel                i_pixel,
    output logic                       empty,
    input  wire logic                  pop,
    output t_result                    o_result,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg     r_cfg;
    logic     accept;
    logic     cmd_push;
    t_cmd     cmd_in;
    logic     cmd_full;
    logic     cmd_empty;
    logic     cmd_pop;
    t_cmd     cmd_head;
    logic     obuf_space;
    t_obuf_wr obuf_wr;

    assign o_cfg_ready = 1'b1;
    assign full        = cmd_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.depth_mode   <= DEPTH_8BIT;
            r_cfg.image_width  <= CFG_DATA_W'(1);
            r_cfg.image_height <= CFG_DATA_W'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DEPTH_MODE:   r_cfg.depth_mode   <= i_cfg_data[1:0];
                CFG_IMAGE_WIDTH:  r_cfg.image_width  <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_cfg.image_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rprle_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_push     (push),
        .i_pixel    (i_pixel),
        .i_cmd_full (cmd_full),
        .o_accept   (accept),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in)
    );

    rprle_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push && accept),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_head),
        .o_empty (cmd_empty)
    );

    rprle_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (!cmd_empty),
        .i_cmd        (cmd_head),
        .o_cmd_pop    (cmd_pop),
        .i_obuf_space (obuf_space),
        .o_obuf_wr    (obuf_wr)
    );

    rprle_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (obuf_wr),
        .o_space  (obuf_space),
        .i_pop    (pop),
        .o_result (o_result),
        .o_empty  (empty)
    );

endmodule

`default_nettype wire

// ===== bench/tb_raster_row_pack_rle_encoder.sv =====
// Self-checking bench for raster_row_pack_rle_encoder: directed vectors, then random
// images with random push/pop gaps, checked word by word against typed words or a local
// encoder model. Depends on rprle_pkg and the encoder RTL only.
`timescale 1ns / 100ps

module tb_raster_row_pack_rle_encoder;
    import rprle_pkg::*;

    localparam int LIMIT_CYCLES  = 1_000_000;
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES   = 600;
    localparam int RAND_PIXELS   = 310;
    localparam int MAX_WORDS     = 15;
    localparam int MAX_REPORTS   = 200;

    localparam logic [7:0]           PAD_BYTE   = 8'h00;
    localparam logic [1:0]           DEPTH_ALT  = 2'd3;  // fourth code, acts as 24-bit
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;  // no register behind it

    localparam int STYLE_FULL   = 0;
    localparam int STYLE_CORNER = 1;
    localparam int STYLE_HELD   = 2;
    localparam int STYLE_SOLID  = 3;

    typedef struct packed {
        logic                  is_reg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        t_pixel                px;
        logic [2:0]            n_typed;  // 0: expectation comes from the model
        t_result [3:0]         typed;    // typed[3] is the first word
    } t_vector;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  push;
    logic                  full;
    t_pixel                i_pixel;
    logic                  empty;
    logic                  pop;
    t_result               o_result;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    raster_row_pack_rle_encoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_pixel     (i_pixel),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // encoder model state
    logic [1:0]  m_depth;
    logic [15:0] m_width;
    logic [15:0] m_height;
    bit          m_run_empty;
    logic [7:0]  m_run_cnt;
    logic [7:0]  m_run_val;
    logic [7:0]  m_bits;
    logic [15:0] m_col;
    logic [15:0] m_row;

    t_result step_words[$];
    t_result pending_words[$];
    t_vector vectors[$];
    t_pixel  held_px;
    bit      calm;
    bit      hold_request;
    int      mismatches;
    int      words_taken;
    int      cycle_count;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch @%0t word %0d: %s", $time, words_taken, what);
    endtask

    function automatic t_result enc_word(input logic [7:0] b, input logic l, input logic e);
        t_result w;
        w.out_byte     = b;
        w.last_of_item = l;
        w.image_end    = e;
        return w;
    endfunction

    function automatic void emit_byte(input logic [7:0] b);
        if (step_words.size() < MAX_WORDS) step_words.push_back(enc_word(b, 1'b0, 1'b0));
    endfunction

    function automatic void flush_run();
        if (m_run_cnt == 8'd0) begin
            emit_byte(m_run_val);
            if (m_run_val == ESC_BYTE) emit_byte(PAD_BYTE);
        end else begin
            emit_byte(ESC_BYTE);
            emit_byte(m_run_cnt);
            emit_byte(m_run_val);
        end
    endfunction

    function automatic void put_byte(input logic [7:0] b);
        if (m_run_empty) begin
            m_run_empty = 1'b0;
            m_run_val   = b;
            m_run_cnt   = 8'd0;
        end else if (b == m_run_val && m_run_cnt != RUN_MAX) begin
            m_run_cnt++;
        end else begin
            flush_run();
            m_run_val = b;
            m_run_cnt = 8'd0;
        end
    endfunction

    // fills step_words with the words one accepted pixel causes
    function automatic void encode_pixel(input t_pixel px);
        logic [15:0] next_col;
        logic [2:0]  partial;
        logic [7:0]  flushed;
        bit          done;
        t_result     w;
        done = 1'b0;
        step_words.delete();
        case (m_depth)
            DEPTH_1BIT: begin
                m_bits = {m_bits[6:0], px.pixel_index[0]};
                if (m_col[2:0] == 3'd7) put_byte(m_bits);
            end
            DEPTH_8BIT: put_byte(px.pixel_index);
            default: begin
                put_byte(px.blue);
                put_byte(px.green);
                put_byte(px.red);
            end
        endcase
        next_col = m_col + 16'd1;
        if (next_col == m_width) begin
            if (m_depth == DEPTH_1BIT) begin
                partial = next_col[2:0];
                flushed = m_bits << (8 - partial);
                if (partial != 3'd0) put_byte(flushed);
                // row byte count is odd unless bit 3 of the last column is set
                if (!m_col[3]) put_byte(PAD_BYTE);
            end else if (next_col[0]) begin
                put_byte(PAD_BYTE);
            end
            m_col = 16'd0;
            if (m_row + 16'd1 == m_height) begin
                if (!m_run_empty) flush_run();
                m_run_empty = 1'b1;
                m_run_cnt   = 8'd0;
                m_run_val   = 8'd0;
                m_row       = 16'd0;
                done        = 1'b1;
            end else begin
                m_row = m_row + 16'd1;
            end
        end else begin
            m_col = next_col;
        end
        if (step_words.size() > 0) begin
            w = step_words.pop_back();
            w.last_of_item = 1'b1;
            w.image_end    = done;
            step_words.push_back(w);
        end
    endfunction

    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    function automatic logic [7:0] corner_byte();
        case ($urandom_range(0, 3))
            0: return 8'h00;
            1: return ESC_BYTE;
            2: return 8'hff;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic t_pixel next_pixel(input int style);
        t_pixel p;
        case (style)
            STYLE_FULL:   p = $urandom;
            STYLE_CORNER: p = {corner_byte(), corner_byte(), corner_byte(), corner_byte()};
            STYLE_HELD: begin
                if ($urandom_range(0, 15) == 0)
                    held_px = {corner_byte(), corner_byte(), corner_byte(), corner_byte()};
                p = held_px;
            end
            default: p = held_px;
        endcase
        return p;
    endfunction

    function automatic t_pixel pix(input logic [7:0] idx, input logic [7:0] r,
                                   input logic [7:0] g, input logic [7:0] b);
        t_pixel p;
        p.pixel_index = idx;
        p.red         = r;
        p.green       = g;
        p.blue        = b;
        return p;
    endfunction

    function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
        t_vector v;
        v          = '0;
        v.is_reg   = 1'b1;
        v.reg_idx  = idx;
        v.reg_data = data;
        vectors.push_back(v);
    endfunction

    function automatic void add_pixel(input t_pixel px, input logic [2:0] n,
                                      input t_result [3:0] typed);
        t_vector v;
        v         = '0;
        v.px      = px;
        v.n_typed = n;
        v.typed   = typed;
        vectors.push_back(v);
    endfunction

    // waits until every expected word is out and the pipeline has gone quiet
    task automatic drain_block();
        push <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        drain_block();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_DEPTH_MODE:   m_depth  = data[1:0];
            CFG_IMAGE_WIDTH:  m_width  = data;
            CFG_IMAGE_HEIGHT: m_height = data;
            default: ;
        endcase
    endtask

    task automatic send_pixel(input t_pixel px, input logic [2:0] n_typed,
                              input t_result [3:0] typed);
        int gap;
        gap = pause_len();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push    <= 1'b1;
        i_pixel <= px;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        encode_pixel(px);
        if (n_typed == 3'd0) begin
            foreach (step_words[i]) pending_words.push_back(step_words[i]);
        end else begin
            for (int i = 0; i < n_typed; i++) pending_words.push_back(typed[3 - i]);
        end
    endtask

    task automatic take_word(input t_result got);
        t_result want;
        words_taken++;
        if (pending_words.size() == 0) begin
            report_mismatch($sformatf("unexpected word %h", got));
            return;
        end
        want = pending_words.pop_front();
        if (got.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte %h, want %h", got.out_byte, want.out_byte));
        if (got.last_of_item !== want.last_of_item)
            report_mismatch($sformatf("last_of_item %b, want %b",
                                      got.last_of_item, want.last_of_item));
        if (got.image_end !== want.image_end)
            report_mismatch($sformatf("image_end %b, want %b", got.image_end, want.image_end));
    endtask

    // result side: random pop gaps, plus one long hold on request
    initial begin
        int stall_left;
        pop <= 1'b0;
        stall_left = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (pop && !empty) take_word(o_result);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                pop <= 1'b0;
                stall_left--;
            end else begin
                pop <= 1'b1;
                stall_left = pause_len();
            end
        end
    end

    initial begin
        logic [1:0]            depth;
        logic [15:0]           wd;
        logic [15:0]           ht;
        logic [CFG_DATA_W-1:0] dword;
        int                    n;
        int                    style;
        int                    phase;
        int                    sent;

        i_rst_n     <= 1'b0;
        push        <= 1'b0;
        i_pixel     <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        cycle_count  = 0;
        mismatches   = 0;
        words_taken  = 0;
        calm         = 1'b0;
        hold_request = 1'b0;
        held_px      = '0;

        m_depth     = DEPTH_8BIT;
        m_width     = 16'd1;
        m_height    = 16'd1;
        m_run_empty = 1'b1;
        m_run_cnt   = 8'd0;
        m_run_val   = 8'd0;
        m_bits      = 8'd0;
        m_col       = 16'd0;
        m_row       = 16'd0;

        // reset values: 8-bit index, one pixel per image
        add_pixel(pix(8'h80, 8'h00, 8'h00, 8'h00), 3'd3,
                  {enc_word(ESC_BYTE, 1'b0, 1'b0), enc_word(8'h00, 1'b0, 1'b0),
                   enc_word(8'h00, 1'b1, 1'b1), enc_word(8'h00, 1'b0, 1'b0)});
        add_pixel(pix(8'hff, 8'hff, 8'hff, 8'hff), 3'd2,
                  {enc_word(8'hff, 1'b0, 1'b0), enc_word(8'h00, 1'b1, 1'b1), 20'h0});
        // pixel and row pad merge into a run of two
        add_pixel(pix(8'h00, 8'h5a, 8'ha5, 8'h3c), 3'd3,
                  {enc_word(ESC_BYTE, 1'b0, 1'b0), enc_word(8'h01, 1'b0, 1'b0),
                   enc_word(8'h00, 1'b1, 1'b1), enc_word(8'h00, 1'b0, 1'b0)});
        add_reg(CFG_DEPTH_MODE, {14'd0, DEPTH_24BIT});
        add_reg(CFG_IMAGE_WIDTH, 16'd2);
        add_reg(CFG_IMAGE_HEIGHT, 16'd2);
        add_pixel(pix(8'h00, 8'h80, 8'h00, 8'hff), 3'd0, '0);
        add_pixel(pix(8'hff, 8'h80, 8'h80, 8'h80), 3'd0, '0);
        add_pixel(pix(8'h55, 8'h00, 8'h00, 8'h00), 3'd0, '0);
        add_pixel(pix(8'haa, 8'hff, 8'hff, 8'hff), 3'd0, '0);
        add_reg(CFG_DEPTH_MODE, {14'd0, DEPTH_ALT});
        add_reg(CFG_IMAGE_WIDTH, 16'd1);
        add_reg(CFG_IMAGE_HEIGHT, 16'd1);
        add_pixel(pix(8'h00, 8'h80, 8'h80, 8'h80), 3'd4,
                  {enc_word(ESC_BYTE, 1'b0, 1'b0), enc_word(8'h02, 1'b0, 1'b0),
                   enc_word(ESC_BYTE, 1'b0, 1'b0), enc_word(8'h00, 1'b1, 1'b1)});
        // 1-bit: nine pixels leave a partial byte, then a 3x2 image with pads
        add_reg(CFG_DEPTH_MODE, {14'd0, DEPTH_1BIT});
        add_reg(CFG_IMAGE_WIDTH, 16'd9);
        add_pixel(pix(8'h01, 8'h00, 8'h00, 8'h00), 3'd0, '0);
        add_pixel(pix(8'hfe, 8'hff, 8'hff, 8'hff), 3'd0, '0);
        add_pixel(pix(8'hff, 8'h00, 8'h00, 8'h00), 3'd0, '0);
        add_pixel(pix(8'h01, 8'h00, 8'h00, 8'h00), 3'd0, '0);
        add_pixel(pix(8'h00, 8'h00, 8'h00, 8'h00), 3'd0, '0);
        add_pixel(pix(8'hfe, 8'h00, 8'h00, 8'h00), 3'd0, '0);
        add_pixel(pix(8'h81, 8'h00, 8'h00, 8'h00), 3'd0, '0);
        add_pixel(pix(8'h7e, 8'h00, 8'h00, 8'h00), 3'd0, '0);
        add_pixel(pix(8'h01, 8'h00, 8'h00, 8'h00), 3'd0, '0);
        add_reg(CFG_IMAGE_WIDTH, 16'd3);
        add_reg(CFG_IMAGE_HEIGHT, 16'd2);
        add_pixel(pix(8'h01, 8'h00, 8'h00, 8'h00), 3'd0, '0);
        add_pixel(pix(8'h00, 8'h00, 8'h00, 8'h00), 3'd0, '0);
        add_pixel(pix(8'h01, 8'h00, 8'h00, 8'h00), 3'd0, '0);
        add_pixel(pix(8'h01, 8'h00, 8'h00, 8'h00), 3'd0, '0);
        add_pixel(pix(8'h01, 8'h00, 8'h00, 8'h00), 3'd0, '0);
        add_pixel(pix(8'h00, 8'h00, 8'h00, 8'h00), 3'd0, '0);
        add_reg(CFG_SPARE, 16'hffff);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (vectors[i]) begin
            if (vectors[i].is_reg) write_reg(vectors[i].reg_idx, vectors[i].reg_data);
            else send_pixel(vectors[i].px, vectors[i].n_typed, vectors[i].typed);
        end

        phase = 0;
        sent  = 0;
        while (sent < RAND_PIXELS) begin
            style   = $urandom_range(STYLE_FULL, STYLE_HELD);
            calm    = ($urandom_range(0, 4) == 0);
            depth   = 2'($urandom_range(0, 3));
            wd      = 16'($urandom_range(1, 12));
            ht      = 16'($urandom_range(1, 3));
            n       = wd * ht * $urandom_range(1, 2);
            if (n > 40) n = 40;
            held_px = $urandom;
            case (phase)
                // long solid run crosses the 256-byte run limit
                0: begin
                    depth   = DEPTH_24BIT;
                    wd      = 16'd88;
                    ht      = 16'd1;
                    n       = 88;
                    style   = STYLE_SOLID;
                    held_px = {4{ESC_BYTE}};
                end
                1: begin
                    depth = DEPTH_1BIT;
                    wd    = 16'hffff;
                    ht    = 16'hffff;
                    n     = 20;
                    style = STYLE_FULL;
                end
                2: begin
                    depth = DEPTH_24BIT;
                    wd    = 16'd8;
                    ht    = 16'd5;
                    n     = 40;
                    style = STYLE_FULL;
                    calm  = 1'b0;
                end
                // zero sizes wrap to 2^16
                3: begin
                    depth = DEPTH_8BIT;
                    wd    = 16'd0;
                    ht    = 16'd0;
                    n     = 12;
                end
                default: begin
                    if ($urandom_range(0, 7) == 0) begin
                        wd = 16'($urandom);
                        ht = 16'($urandom);
                        n  = $urandom_range(5, 20);
                    end
                end
            endcase
            dword      = CFG_DATA_W'($urandom);
            dword[1:0] = depth;
            write_reg(CFG_DEPTH_MODE, dword);
            write_reg(CFG_IMAGE_WIDTH, wd);
            write_reg(CFG_IMAGE_HEIGHT, ht);
            // block fills up while the sender keeps pushing
            if (phase == 2) hold_request = 1'b1;
            repeat (n) begin
                send_pixel(next_pixel(style), 3'd0, '0);
                sent++;
            end
            // close an unfinished image with a size that ends at the next pixel
            if (m_col != 16'd0 || m_row != 16'd0) begin
                write_reg(CFG_IMAGE_WIDTH, m_col + 16'd1);
                write_reg(CFG_IMAGE_HEIGHT, m_row + 16'd1);
                send_pixel(next_pixel(style), 3'd0, '0);
                sent++;
            end
            phase++;
        end

        drain_block();
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
